// ----- hw/rtl/lfrt_pkg.sv -----
// shared types, constants and helpers for the laser frame sync and range tracker
// no dependencies; used by lfrt_sync, lfrt_track and the top level
package lfrt_pkg;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int CTR_W    = 2;
   localparam int DIST_W   = 23;
   localparam int IPC_W    = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = COUNT_W + IPC_W;
   localparam int FRAC_DROP = 16;
   localparam int RND_W    = PROD_W - FRAC_DROP;
   localparam int SUM_W    = RND_W + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_DROP - 1);

   // register reset values
   localparam logic [DIST_W-1:0] BASE_OFFSET_RST = DIST_W'(322522);
   localparam logic [IPC_W-1:0]  IPC_RST         = IPC_W'(5160305);
   localparam logic [DIST_W-1:0] THRESHOLD_RST   = DIST_W'(655);

   // group of four bytes, fill index of the last byte
   localparam logic [1:0] FILL_LAST = 2'd3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPTURE_ENABLE = 2'd0,
      CSR_BASE_OFFSET    = 2'd1,
      CSR_INCH_PER_COUNT = 2'd2,
      CSR_THRESHOLD      = 2'd3
   } csr_index_type;

   // input beat codes
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // result codes
   localparam logic KIND_READING = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic                    capture;
      logic [DIST_W-1:0]       base;
      logic [IPC_W-1:0]        ipc;
      logic [DIST_W-1:0]       thr;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic [COUNT_W-1:0]      counts;
      logic [CTR_W-1:0]        ctr;
   } group_type;

   typedef struct packed {
      logic                    valid;
      logic                    kind;
      logic [COUNT_W-1:0]      counts;
      logic [CTR_W-1:0]        ctr;
      logic [DIST_W-1:0]       distance;
      logic [DIST_W-1:0]       omin;
      logic [DIST_W-1:0]       omax;
      logic                    changing;
   } result_type;

   // frame counter lives in bits 5:4
   function automatic logic [CTR_W-1:0] frame_ctr(input logic [BYTE_W-1:0] b);
      return b[5:4];
   endfunction

endpackage

// ----- hw/rtl/lfrt_sync.sv -----
// frame alignment: holds the first three bytes of a group, checks the frame counters
// and drops bytes to realign; depends on lfrt_pkg
module lfrt_sync (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          is_byte,
   input  logic [lfrt_pkg::BYTE_W-1:0]   byte_in,
   output lfrt_pkg::group_type           group
);

   logic [lfrt_pkg::BYTE_W-1:0] held_ff [3];
   logic [1:0] fill_ff, fill_in;
   logic [1:0] drop_ff, drop_in;
   logic       hold_en;
   logic [1:0] off;
   logic [lfrt_pkg::CTR_W-1:0] c0;

   assign c0 = lfrt_pkg::frame_ctr(held_ff[0]);

   always_comb begin
      if (lfrt_pkg::frame_ctr(held_ff[1]) != c0) begin
         off = 2'd1;
      end else if (lfrt_pkg::frame_ctr(held_ff[2]) != c0) begin
         off = 2'd2;
      end else if (lfrt_pkg::frame_ctr(byte_in) != c0) begin
         off = 2'd3;
      end else begin
         off = 2'd0;
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      hold_en      = 1'b0;
      group.valid  = 1'b0;
      group.ctr    = c0;
      group.counts = {byte_in[3:0], held_ff[2][3:0], held_ff[1][3:0], held_ff[0][3:0]};
      if (step && is_byte) begin
         if (drop_ff != 2'd0) begin
            drop_in = drop_ff - 2'd1;
         end else if (fill_ff != lfrt_pkg::FILL_LAST) begin
            hold_en = 1'b1;
            fill_in = fill_ff + 2'd1;
         end else begin
            fill_in = 2'd0;
            if (off != 2'd0) begin
               drop_in = off;
            end else begin
               group.valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         drop_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         drop_ff <= drop_in;
      end
   end

   // held bytes need no reset, only read after written within the group
   always_ff @(posedge clock) begin
      if (hold_en) begin
         held_ff[fill_ff] <= byte_in;
      end
   end

endmodule

// ----- hw/rtl/lfrt_track.sv -----
// distance conversion plus window and overall min/max tracking and tick verdicts
// depends on lfrt_pkg
module lfrt_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  is_tick,
   input  lfrt_pkg::cfg_type     cfg,
   input  lfrt_pkg::group_type   group,
   output lfrt_pkg::result_type  result
);

   logic [lfrt_pkg::DIST_W-1:0] win_low_ff, win_low_in;
   logic [lfrt_pkg::DIST_W-1:0] win_high_ff, win_high_in;
   logic [lfrt_pkg::DIST_W-1:0] tot_low_ff, tot_low_in;
   logic [lfrt_pkg::DIST_W-1:0] tot_high_ff, tot_high_in;

   logic [lfrt_pkg::PROD_W-1:0] prod;
   logic [lfrt_pkg::PROD_W-1:0] prod_rnd;
   logic [lfrt_pkg::SUM_W-1:0]  dist_sum;
   logic [lfrt_pkg::DIST_W-1:0] distance;
   logic [lfrt_pkg::DIST_W:0]   thr_sum;
   logic                        do_read;
   logic                        do_tick;
   logic                        changing;

   // counts * inches per count, rounded half up into q16, plus base, saturated
   assign prod     = lfrt_pkg::PROD_W'(group.counts) * lfrt_pkg::PROD_W'(cfg.ipc);
   assign prod_rnd = prod + lfrt_pkg::ROUND_HALF;
   assign dist_sum = lfrt_pkg::SUM_W'(cfg.base)
                   + lfrt_pkg::SUM_W'(prod_rnd[lfrt_pkg::PROD_W-1:lfrt_pkg::FRAC_DROP]);

   always_comb begin
      if (group.counts == '0) begin
         distance = '0;
      end else if (dist_sum > lfrt_pkg::SUM_W'(lfrt_pkg::DIST_MAX)) begin
         distance = lfrt_pkg::DIST_MAX;
      end else begin
         distance = dist_sum[lfrt_pkg::DIST_W-1:0];
      end
   end

   assign thr_sum  = {1'b0, win_low_ff} + {1'b0, cfg.thr};
   assign changing = {1'b0, win_high_ff} > thr_sum;

   assign do_read = step && group.valid && cfg.capture;
   assign do_tick = step && is_tick && cfg.capture;

   always_comb begin
      win_low_in  = win_low_ff;
      win_high_in = win_high_ff;
      tot_low_in  = tot_low_ff;
      tot_high_in = tot_high_ff;
      if (do_tick) begin
         win_low_in  = lfrt_pkg::DIST_MAX;
         win_high_in = '0;
      end else if (do_read) begin
         if (distance < win_low_ff)  win_low_in  = distance;
         if (distance > win_high_ff) win_high_in = distance;
         if (distance < tot_low_ff)  tot_low_in  = distance;
         if (distance > tot_high_ff) tot_high_in = distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff  <= lfrt_pkg::DIST_MAX;
         win_high_ff <= '0;
         tot_low_ff  <= lfrt_pkg::DIST_MAX;
         tot_high_ff <= '0;
      end else begin
         win_low_ff  <= win_low_in;
         win_high_ff <= win_high_in;
         tot_low_ff  <= tot_low_in;
         tot_high_ff <= tot_high_in;
      end
   end

   always_comb begin
      result.valid    = do_read || do_tick;
      result.omin     = tot_low_in;
      result.omax     = tot_high_in;
      if (do_tick) begin
         result.kind     = lfrt_pkg::KIND_VERDICT;
         result.counts   = '0;
         result.ctr      = '0;
         result.distance = '0;
         result.changing = changing;
      end else begin
         result.kind     = lfrt_pkg::KIND_READING;
         result.counts   = group.counts;
         result.ctr      = group.ctr;
         result.distance = distance;
         result.changing = 1'b0;
      end
   end

endmodule

// ----- hw/rtl/laser_frame_sync_and_range_tracker.sv -----
// top level of the laser frame sync and range tracker: input register, config
// registers, result register; depends on lfrt_pkg, lfrt_sync and lfrt_track
//
// Serial bytes from a distance laser arrive one per beat on the req_ channel
// (req_type 0) and are grouped by fours; a group is kept when the frame
// counters in bits 5:4 agree, otherwise up to three bytes are dropped to
// realign. With capture enabled, a kept group yields one reading beat on rsp_
// (raw count, frame counter, q16 distance, overall min/max) and a tick beat
// (req_type 1) yields one verdict beat and clears the window. Bytes that only
// fill, drop or fail a group, and anything with capture off, give no beat.
// The block takes one beat per cycle while rsp_stall does not hold it: while
// a beat sits in the input register, the frame check, the 16x24 distance
// multiply with round, add and saturate, and the min/max compares run in that
// single stage, and the result register loads on the next edge and offers
// the result on rsp_. That multiply-add-compare path sets the clock.
// rsp_stall holds the result register and, once the input register is also
// full, raises req_stall. Configuration writes through csr_ take effect on
// the next edge and are meant to happen only while the block is idle.
module laser_frame_sync_and_range_tracker (
   input  logic                              clock,
   input  logic                              reset,

   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [lfrt_pkg::BYTE_W-1:0]       req_data_byte,

   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_result_kind,
   output logic [lfrt_pkg::COUNT_W-1:0]      rsp_raw_counts,
   output logic [lfrt_pkg::CTR_W-1:0]        rsp_frame_counter,
   output logic [lfrt_pkg::DIST_W-1:0]       rsp_distance_q16,
   output logic [lfrt_pkg::DIST_W-1:0]       rsp_overall_min_q16,
   output logic [lfrt_pkg::DIST_W-1:0]       rsp_overall_max_q16,
   output logic                              rsp_is_changing,

   // configuration write port
   input  logic                              csr_write_en,
   input  logic [lfrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfrt_pkg::CSR_W-1:0]        csr_write_data
);

   // config registers
   lfrt_pkg::cfg_type cfg_ff, cfg_in;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic                         in_type_ff;
   logic [lfrt_pkg::BYTE_W-1:0]  in_byte_ff;

   // result register
   logic                         out_valid_ff, out_valid_in;
   lfrt_pkg::result_type         out_ff;

   logic                         out_free;
   logic                         step;
   logic                         accept;
   lfrt_pkg::group_type          group;
   lfrt_pkg::result_type         result;

   // --------------------------------------------------------------------
   // handshake: the input register advances whenever the result register
   // is empty or being drained this cycle
   // --------------------------------------------------------------------
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step && result.valid) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_data_byte;
      end
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   // --------------------------------------------------------------------
   // configuration registers
   // --------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (lfrt_pkg::csr_index_type'(csr_index))
            lfrt_pkg::CSR_CAPTURE_ENABLE: cfg_in.capture = csr_write_data[0];
            lfrt_pkg::CSR_BASE_OFFSET:
               cfg_in.base = csr_write_data[lfrt_pkg::DIST_W-1:0];
            lfrt_pkg::CSR_INCH_PER_COUNT:
               cfg_in.ipc = csr_write_data[lfrt_pkg::IPC_W-1:0];
            lfrt_pkg::CSR_THRESHOLD:
               cfg_in.thr = csr_write_data[lfrt_pkg::DIST_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capture <= 1'b0;
         cfg_ff.base    <= lfrt_pkg::BASE_OFFSET_RST;
         cfg_ff.ipc     <= lfrt_pkg::IPC_RST;
         cfg_ff.thr     <= lfrt_pkg::THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --------------------------------------------------------------------
   // execute stage: frame alignment, then distance and tracking
   // --------------------------------------------------------------------
   lfrt_sync u_sync (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .is_byte (in_type_ff == lfrt_pkg::REQ_BYTE),
      .byte_in (in_byte_ff),
      .group   (group)
   );

   lfrt_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .is_tick (in_type_ff == lfrt_pkg::REQ_TICK),
      .cfg     (cfg_ff),
      .group   (group),
      .result  (result)
   );

   // result beat
   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_ff.kind;
   assign rsp_raw_counts      = out_ff.counts;
   assign rsp_frame_counter   = out_ff.ctr;
   assign rsp_distance_q16    = out_ff.distance;
   assign rsp_overall_min_q16 = out_ff.omin;
   assign rsp_overall_max_q16 = out_ff.omax;
   assign rsp_is_changing     = out_ff.changing;

endmodule
